@@ src/lliuc_pkg.sv @@
// ----------------------------------------------------------------------------
// lliuc_pkg
// Shared widths, constants and hand-off types for the line length in cell
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lliuc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  // corner side value: y*2^F - m*x - b*2^F plus half-cell offsets
  localparam int S_W       = 2 * IN_W + 2;
  localparam int AM_W      = IN_W;
  localparam int NUM_W     = S_W;
  // dx and dy never exceed 2^(F+1)
  localparam int D_W       = FRAC_BITS + 2;
  localparam int SQ_W      = 2 * D_W;
  localparam int LEN_W     = 17;

  localparam logic [D_W-1:0]  D_MAX = D_W'(1) << (FRAC_BITS + 1);
  localparam logic [D_W-1:0]  ONE_D = D_W'(1) << FRAC_BITS;
  localparam logic [AM_W-1:0] ONE_M = AM_W'(1) << FRAC_BITS;

  // work handed from the corner stages to the divider
  typedef struct packed {
    logic             hit;
    logic             div;
    logic [NUM_W-1:0] num;
    logic [AM_W-1:0]  am;
    logic [D_W-1:0]   dx;
    logic [D_W-1:0]   dy;
  } lliuc_job_t;

  // crossing distances handed to the length stages
  typedef struct packed {
    logic           hit;
    logic [D_W-1:0] dx;
    logic [D_W-1:0] dy;
  } lliuc_dist_t;

endpackage

`default_nettype wire

@@ src/lliuc_corner.sv @@
// ----------------------------------------------------------------------------
// lliuc_corner
// Corner side evaluation, sign classification and set-up of the dx/dy work.
// ----------------------------------------------------------------------------
`default_nettype none

module lliuc_corner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [lliuc_pkg::IN_W-1:0]   cell_x_i,
  input  logic signed [lliuc_pkg::IN_W-1:0]   cell_y_i,
  input  logic signed [lliuc_pkg::IN_W-1:0]   slope_i,
  input  logic signed [lliuc_pkg::IN_W-1:0]   intercept_i,
  output logic                                valid_o,
  output lliuc_pkg::lliuc_job_t               job_o
);
  import lliuc_pkg::*;

  localparam logic signed [S_W-1:0] HalfSq = S_W'(1) << (2 * FRAC_BITS - 1);

  function automatic logic signed [S_W-1:0] sext(input logic signed [IN_W-1:0] v);
    return {{(S_W-IN_W){v[IN_W-1]}}, v};
  endfunction

  // lowest-index minimum (or maximum) among corners lo..3
  function automatic logic [1:0] pick(input logic [3:0][3:0] lt, input logic want_min,
                                      input int lo);
    logic [1:0] idx;
    logic       ok;
    idx = 2'(lo);
    for (int j = 3; j >= 0; j--) begin
      if (j >= lo) begin
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (k >= lo && k != j) begin
            if (want_min) ok = ok & ((k < j) ? lt[j][k] : !lt[k][j]);
            else          ok = ok & ((k < j) ? lt[k][j] : !lt[j][k]);
          end
        end
        if (ok) idx = 2'(j);
      end
    end
    return idx;
  endfunction

  logic [6:0] v_q;

  // stage 1
  logic signed [2*IN_W-1:0] prod_q;
  logic signed [IN_W-1:0]   y1_q, b1_q, m1_q;
  // stage 2
  logic signed [S_W-1:0]    a_q, mh_q;
  logic [AM_W-1:0]          am2_q;
  // stage 3
  logic signed [S_W-1:0]    s3_q [4];
  logic [AM_W-1:0]          am3_q;
  // stage 4
  logic signed [S_W-1:0]    s4_q [4];
  logic [3:0][3:0]          lt_q;
  logic [3:0]               pos_q, neg_q;
  logic [AM_W-1:0]          am4_q;
  // stage 5
  logic signed [S_W-1:0]    sel_q;
  logic [1:0]               j5_q;
  logic                     tri5_q, two5_q;
  logic [AM_W-1:0]          am5_q;
  // stage 6
  logic [S_W-1:0]           c_q;
  logic [1:0]               j6_q;
  logic                     tri6_q, two6_q;
  logic [AM_W-1:0]          am6_q;
  // stage 7
  lliuc_job_t               job_q;

  logic signed [S_W-1:0] a_d;
  logic [AM_W-1:0]       am_d;
  logic [3:0][3:0]       lt_d;
  logic [2:0]            npos, nneg;
  logic                  tri_d, two_d;
  logic [1:0]            j_d;
  logic [S_W-1:0]        dyr;
  lliuc_job_t            job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  assign a_d  = (sext(y1_q) <<< FRAC_BITS) - (sext(b1_q) <<< FRAC_BITS)
              - {{(S_W-2*IN_W){prod_q[2*IN_W-1]}}, prod_q};
  assign am_d = m1_q[IN_W-1] ? AM_W'(-m1_q) : AM_W'(m1_q);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        lt_d[i][k] = s3_q[i] < s3_q[k];
      end
    end
  end

  assign npos  = 3'($countones(pos_q));
  assign nneg  = 3'($countones(neg_q));
  assign tri_d = (npos == 3'd3) || (nneg == 3'd3);
  assign two_d = !tri_d && ((npos == 3'd2) || (nneg == 3'd2));
  assign j_d   = tri_d ? pick(lt_q, npos == 3'd3, 0) : pick(lt_q, neg_q[0], 1);

  assign dyr = (c_q + (S_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_comb begin
    job_d     = '0;
    job_d.am  = am6_q;
    job_d.hit = tri6_q | two6_q;
    if (tri6_q) begin
      job_d.dy  = (dyr > S_W'(D_MAX)) ? D_MAX : dyr[D_W-1:0];
      job_d.num = c_q + NUM_W'(am6_q >> 1);
      if (am6_q == '0) begin
        job_d.dx = D_MAX;
      end else begin
        job_d.div = 1'b1;
      end
    end else if (two6_q) begin
      if (am6_q < ONE_M) begin
        // crossings at the corners' x: only a change of column gives a length
        if (j6_q[0]) begin
          job_d.dx = ONE_D;
          job_d.dy = am6_q[D_W-1:0];
        end
      end else if (j6_q[1]) begin
        job_d.dy  = ONE_D;
        job_d.div = 1'b1;
        job_d.num = (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(am6_q >> 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= slope_i * cell_x_i;
      y1_q   <= cell_y_i;
      b1_q   <= intercept_i;
      m1_q   <= slope_i;

      a_q    <= a_d;
      mh_q   <= sext(m1_q) <<< (FRAC_BITS - 1);
      am2_q  <= am_d;

      s3_q[0] <= a_q - HalfSq + mh_q;
      s3_q[1] <= a_q - HalfSq - mh_q;
      s3_q[2] <= a_q + HalfSq + mh_q;
      s3_q[3] <= a_q + HalfSq - mh_q;
      am3_q   <= am2_q;

      for (int i = 0; i < 4; i++) begin
        s4_q[i]  <= s3_q[i];
        pos_q[i] <= s3_q[i] > 0;
        neg_q[i] <= s3_q[i] < 0;
      end
      lt_q   <= lt_d;
      am4_q  <= am3_q;

      sel_q  <= s4_q[j_d];
      j5_q   <= j_d;
      tri5_q <= tri_d;
      two5_q <= two_d;
      am5_q  <= am4_q;

      c_q    <= sel_q[S_W-1] ? S_W'(-sel_q) : S_W'(sel_q);
      j6_q   <= j5_q;
      tri6_q <= tri5_q;
      two6_q <= two5_q;
      am6_q  <= am5_q;

      job_q  <= job_d;
    end
  end

  assign valid_o = v_q[6];
  assign job_o   = job_q;

endmodule

`default_nettype wire

@@ src/lliuc_div.sv @@
// ----------------------------------------------------------------------------
// lliuc_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module lliuc_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  lliuc_pkg::lliuc_job_t  job_i,
  output logic                   valid_o,
  output lliuc_pkg::lliuc_dist_t dist_o
);
  import lliuc_pkg::*;

  localparam int NS = D_W + 1;

  typedef struct packed {
    logic             hit;
    logic             div;
    logic             ovf;
    logic [AM_W-1:0]  am;
    logic [NUM_W-1:0] rem;
    logic [D_W-1:0]   q;
    logic [D_W-1:0]   dx;
    logic [D_W-1:0]   dy;
  } dstep_t;

  logic [NS-1:0] v_q;
  dstep_t        st_q [NS];
  dstep_t        st0_d;
  logic          vout_q;
  lliuc_dist_t   dist_q, dist_d;

  always_comb begin
    st0_d     = '0;
    st0_d.hit = job_i.hit;
    st0_d.div = job_i.div;
    st0_d.am  = job_i.am;
    st0_d.rem = job_i.num;
    st0_d.dx  = job_i.dx;
    st0_d.dy  = job_i.dy;
    // quotient of 2^D_W or more is far past saturation
    st0_d.ovf = job_i.div && (job_i.num >= (NUM_W'(job_i.am) << D_W));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar gi = 0; gi < D_W; gi++) begin : g_step
    localparam int Bit = D_W - 1 - gi;
    dstep_t           nx_d;
    logic [NUM_W-1:0] sh;

    always_comb begin
      nx_d = st_q[gi];
      sh   = NUM_W'(st_q[gi].am) << Bit;
      if (st_q[gi].div && !st_q[gi].ovf && (st_q[gi].rem >= sh)) begin
        nx_d.rem    = st_q[gi].rem - sh;
        nx_d.q[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        v_q[gi+1] <= v_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[gi+1] <= nx_d;
      end
    end
  end

  always_comb begin
    dist_d.hit = st_q[NS-1].hit;
    dist_d.dy  = st_q[NS-1].dy;
    if (!st_q[NS-1].div) begin
      dist_d.dx = st_q[NS-1].dx;
    end else if (st_q[NS-1].ovf || (st_q[NS-1].q > D_MAX)) begin
      dist_d.dx = D_MAX;
    end else begin
      dist_d.dx = st_q[NS-1].q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign valid_o = vout_q;
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

@@ src/lliuc_sqrt.sv @@
// ----------------------------------------------------------------------------
// lliuc_sqrt
// Squares, sum and pipelined digit-by-digit square root with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module lliuc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  lliuc_pkg::lliuc_dist_t        dist_i,
  output logic                          valid_o,
  output logic [lliuc_pkg::LEN_W-1:0]   len_o,
  output logic                          crossed_o
);
  import lliuc_pkg::*;

  localparam int RW = SQ_W + 1;
  localparam logic [D_W:0] LenMax = (D_W+1)'((1 << LEN_W) - 1);

  typedef struct packed {
    logic           hit;
    logic [RW-1:0]  rem;
    logic [D_W-1:0] root;
  } rstep_t;

  logic [D_W+1:0]   v_q;
  logic [SQ_W-1:0]  dx2_q, dy2_q;
  logic             hit_q;
  rstep_t           st_q [D_W+1];
  rstep_t           st0_d;
  logic             vout_q;
  logic [LEN_W-1:0] len_q;
  logic             crossed_q;
  logic [D_W:0]     rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      v_q    <= {v_q[D_W:0], valid_i};
      vout_q <= v_q[D_W+1];
    end
  end

  always_comb begin
    st0_d      = '0;
    st0_d.hit  = hit_q;
    st0_d.rem  = RW'(dx2_q) + RW'(dy2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx2_q   <= dist_i.dx * dist_i.dx;
      dy2_q   <= dist_i.dy * dist_i.dy;
      hit_q   <= dist_i.hit;
      st_q[0] <= st0_d;
    end
  end

  for (genvar gi = 0; gi < D_W; gi++) begin : g_root
    localparam int Bit = D_W - 1 - gi;
    rstep_t        nx_d;
    logic [RW-1:0] trial;

    always_comb begin
      nx_d  = st_q[gi];
      // (r + 2^b)^2 - r^2
      trial = (RW'(st_q[gi].root) << (Bit + 1)) + (RW'(1) << (2 * Bit));
      if (st_q[gi].rem >= trial) begin
        nx_d.rem       = st_q[gi].rem - trial;
        nx_d.root[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[gi+1] <= nx_d;
      end
    end
  end

  assign rnd = (st_q[D_W].rem > RW'(st_q[D_W].root)) ? ((D_W+1)'(st_q[D_W].root) + 1'b1)
                                                       : (D_W+1)'(st_q[D_W].root);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q     <= (rnd > LenMax) ? LenMax[LEN_W-1:0] : rnd[LEN_W-1:0];
      crossed_q <= st_q[D_W].hit;
    end
  end

  assign valid_o   = vout_q;
  assign len_o     = len_q;
  assign crossed_o = crossed_q;

endmodule

`default_nettype wire

@@ src/line_length_in_unit_cell.sv @@
// ----------------------------------------------------------------------------
// line_length_in_unit_cell
// Length of the line y = m*x + b inside the unit cell around a centre point.
// ----------------------------------------------------------------------------
// channel  direction  handshake                    payload
// s_axis   in         s_axis_tvalid/s_axis_tready  cell_x, cell_y, slope, intercept
// m_axis   out        m_axis_tvalid/m_axis_tready  seg_length (tdata), crossed (tuser)
//
// one request per cycle while m_axis does not stall; the pipeline is 7 corner stages, 20 divider
// stages and 21 square root stages from request to result
// the divider and square root each resolve one bit per stage
// reset clears only the valid bits; no clearing pass is needed
// a stall on m_axis freezes the whole pipeline and holds s_axis_tready low
// ----------------------------------------------------------------------------
`default_nettype none

module line_length_in_unit_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_x[31:0], cell_y[63:32], slope[95:64], intercept[127:96]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // seg_length[16:0], zero fill [23:17]
  output logic [23:0]  m_axis_tdata,
  // crossed[0]
  output logic [0:0]   m_axis_tuser
);
  import lliuc_pkg::*;

  logic        adv;
  logic        job_vld, dist_vld, out_vld;
  lliuc_job_t  job;
  lliuc_dist_t span;
  logic [LEN_W-1:0] len;
  logic        crossed;

  // the pipeline moves whenever the output slot is free or being taken
  assign adv           = !out_vld || m_axis_tready;
  assign s_axis_tready = adv;

  lliuc_corner u_corner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (s_axis_tvalid),
    .cell_x_i    (s_axis_tdata[31:0]),
    .cell_y_i    (s_axis_tdata[63:32]),
    .slope_i     (s_axis_tdata[95:64]),
    .intercept_i (s_axis_tdata[127:96]),
    .valid_o     (job_vld),
    .job_o       (job)
  );

  lliuc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (job_vld),
    .job_i   (job),
    .valid_o (dist_vld),
    .dist_o  (span)
  );

  lliuc_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (dist_vld),
    .dist_i    (span),
    .valid_o   (out_vld),
    .len_o     (len),
    .crossed_o (crossed)
  );

  assign m_axis_tvalid   = out_vld;
  assign m_axis_tdata    = {(24-LEN_W)'(0), len};
  assign m_axis_tuser[0] = crossed;

endmodule

`default_nettype wire

@@ sim/line_length_in_unit_cell_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_length_in_unit_cell_checker
// Watches both stream channels, predicts the crossing length of every
// accepted request and compares it in order with the results that emerge.
// ----------------------------------------------------------------------------
`default_nettype none

module line_length_in_unit_cell_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [23:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           errors_o,
  output int           pending_o
);
  import lliuc_pkg::*;

  typedef struct packed {
    logic [16:0] seg_length;
    logic        crossed;
  } seg_t;

  seg_t seg_q[$];

  assign pending_o = seg_q.size();

  function automatic logic [63:0] root_nearest(logic [63:0] v);
    logic [63:0] rem, r, bt;
    rem = v;
    r   = 0;
    bt  = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic seg_t predict_length(logic [127:0] d);
    longint      cx, cy, m, b, px, py;
    longint      s[4];
    logic [63:0] am, c, dx, dy, len;
    int          pos, neg, j;
    seg_t        res;
    cx  = longint'(signed'(d[31:0]));
    cy  = longint'(signed'(d[63:32]));
    m   = longint'(signed'(d[95:64]));
    b   = longint'(signed'(d[127:96]));
    am  = m < 0 ? -m : m;
    pos = 0;
    neg = 0;
    dx  = 0;
    dy  = 0;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      px   = i[0] ? cx + (1 << (FRAC_BITS - 1)) : cx - (1 << (FRAC_BITS - 1));
      py   = i[1] ? cy + (1 << (FRAC_BITS - 1)) : cy - (1 << (FRAC_BITS - 1));
      s[i] = (py <<< FRAC_BITS) - m * px - (b <<< FRAC_BITS);
      if (s[i] > 0) pos++;
      if (s[i] < 0) neg++;
    end
    if (pos == 3 || neg == 3) begin
      j = 0;
      for (int i = 1; i < 4; i++)
        if (pos == 3 ? s[i] < s[j] : s[i] > s[j]) j = i;
      c  = s[j] < 0 ? -s[j] : s[j];
      dy = (c + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      dx = am != 0 ? (c + (am >> 1)) / am : 64'(D_MAX);
      res.crossed = 1'b1;
    end else if (pos == 2 || neg == 2) begin
      j = 1;
      for (int i = 2; i < 4; i++)
        if (s[0] < 0 ? s[i] < s[j] : s[i] > s[j]) j = i;
      if (am < (64'd1 << FRAC_BITS)) begin
        if (j[0]) begin
          dx = 64'd1 << FRAC_BITS;
          dy = am;
        end
      end else if (j[1]) begin
        dy = 64'd1 << FRAC_BITS;
        dx = ((64'd1 << (2 * FRAC_BITS)) + (am >> 1)) / am;
      end
      res.crossed = 1'b1;
    end
    if (res.crossed) begin
      if (dx > 64'(D_MAX)) dx = 64'(D_MAX);
      if (dy > 64'(D_MAX)) dy = 64'(D_MAX);
      len = root_nearest(dx * dx + dy * dy);
      res.seg_length = len > 64'h1FFFF ? 17'h1FFFF : len[16:0];
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i) begin
    seg_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (seg_q.size() == 0) begin
          report("unexpected result", m_axis_tdata, 0);
        end else begin
          want = seg_q.pop_front();
          if (m_axis_tdata[16:0] !== want.seg_length)
            report("seg_length", m_axis_tdata[16:0], want.seg_length);
          if (m_axis_tdata[23:17] !== 7'd0)
            report("fill", m_axis_tdata[23:17], 0);
          if (m_axis_tuser[0] !== want.crossed)
            report("crossed", m_axis_tuser[0], want.crossed);
        end
      end
      if (s_axis_tvalid && s_axis_tready) seg_q.push_back(predict_length(s_axis_tdata));
    end
  end

endmodule

`default_nettype wire

@@ sim/line_length_in_unit_cell_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_length_in_unit_cell_tb
// Drives directed and random cell and line requests with random gaps and
// back-pressure; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`default_nettype none

module line_length_in_unit_cell_tb;
  localparam int  LIMIT = 400000;
  localparam int  ONE   = 32'h10000;
  localparam int  HALF  = 32'h8000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           errors, pending;
  int           cycles = 0;
  bit           hold_rx = 1'b0;

  line_length_in_unit_cell DUT (.*);

  line_length_in_unit_cell_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("line_length_in_unit_cell_tb: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && ($urandom_range(4) == 0)) begin
        g = gap_len();
        m_axis_tready <= (g == 0);
        repeat (g) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [31:0] x, y, m, b, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata  <= {b, m, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_line(bit gaps);
    logic [31:0] x, y, m, b;
    int k;
    k = $urandom_range(9);
    x = $urandom;
    m = $urandom;
    b = $urandom;
    if (k < 7) begin
      // keep the line near the cell so that it usually crosses
      x = $urandom_range(ONE * 64) - ONE * 32;
      case ($urandom_range(3))
        0: m = $urandom_range(ONE - 1);
        1: m = $urandom_range(ONE * 8);
        2: m = $urandom_range(2 * ONE) - ONE;
        default: m = $urandom_range(ONE * 64) - ONE * 32;
      endcase
      if ($urandom_range(1)) m = -m;
      b = $urandom_range(ONE * 64) - ONE * 32;
      y = 32'((longint'(signed'(m)) * longint'(signed'(x)) >>> 16)
            + longint'(signed'(b))) + $urandom_range(2 * ONE) - ONE;
    end else begin
      y = $urandom;
    end
    send_request(x, y, m, b, gaps);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: field extremes, flat, steep, diagonal and corner-touching lines
    send_request(32'h0, 32'h0, 32'h0, 32'h0, 0);
    send_request(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_request(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_request(32'hFFFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF, 0);
    send_request(32'h0, 32'h0, ONE, 32'h0, 0);
    send_request(32'h0, 32'h0, -ONE, 32'h0, 0);
    send_request(32'h0, 32'h0, ONE, 32'h4000, 0);
    send_request(32'h0, 32'h0, -ONE, -32'h4000, 0);
    send_request(32'h0, 32'h0, ONE - 1, 32'h0, 0);
    send_request(32'h0, 32'h0, ONE + 1, 32'h0, 0);
    send_request(32'h0, 32'h0, ONE * 100, 32'h0, 0);
    send_request(32'h0, 32'h0, 32'h0, 32'h1000, 0);
    send_request(32'h0, 32'h0, 32'h0, HALF, 0);
    send_request(32'h0, 32'h0, 32'h0, -HALF, 0);
    send_request(32'h0, 32'h0, ONE, ONE, 0);
    send_request(ONE, 32'h0, 2 * ONE, -ONE, 0);
    send_request(32'h0, 32'h0, 32'h1, 32'h0, 0);
    send_request(32'h0, 32'h0, ONE / 2, 32'h6000, 0);
    send_request(32'h0, 32'h0, -3 * ONE, 32'h10000, 0);
    send_request(32'h12345, 32'hFFFF0000, 32'h7FFFFFFF, 32'h0, 0);
    drain();
    // back-pressure: hold the receiver while requests keep coming
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (120) random_line(0);
    join
    // sender pauses until everything has come back
    drain();
    repeat (1000) random_line($urandom_range(2) == 0);
    drain();
    if (errors == 0) begin
      $display("line_length_in_unit_cell_tb: clean");
    end else begin
      $display("line_length_in_unit_cell_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ line_length_in_unit_cell.f @@
src/lliuc_pkg.sv
src/lliuc_corner.sv
src/lliuc_div.sv
src/lliuc_sqrt.sv
src/line_length_in_unit_cell.sv
sim/line_length_in_unit_cell_checker.sv
sim/line_length_in_unit_cell_tb.sv
